// ===== rtl/pnns_pkg.sv =====
// ----------------------------------------------------------------------------
// pnns_pkg
// Shared types, widths and register codes for the projected nearest
// neighbour search block.
// ----------------------------------------------------------------------------
package pnns_pkg;

  // map store geometry
  localparam int MAP_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int CNT_W     = ADDR_W + 1;

  // field and datapath widths
  localparam int COORD_W = 16;
  localparam int PROD_W  = 33;
  localparam int SHIFT   = 12;
  localparam int QUOT_W  = PROD_W - SHIFT;
  localparam int PROJ_W  = QUOT_W + 1;
  localparam int DIFF_W  = PROJ_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = 42;
  localparam int IDX_W   = 10;
  localparam int MCNT_W  = 11;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT = 3'd4;

  localparam logic [COORD_W-1:0] FOCAL_X_RST  = 16'd16384;
  localparam logic [COORD_W-1:0] FOCAL_Y_RST  = 16'd16384;
  localparam logic [COORD_W-1:0] CENTRE_X_RST = 16'd10240;
  localparam logic [COORD_W-1:0] CENTRE_Y_RST = 16'd7680;
  localparam logic [MCNT_W-1:0]  MAP_COUNT_RST = 11'd0;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          entry_index;
    logic signed [COORD_W-1:0] star_x;
    logic signed [COORD_W-1:0] star_y;
    logic [COORD_W-1:0]        det_x;
    logic [COORD_W-1:0]        det_y;
  } in_t;

  typedef struct packed {
    logic              match_found;
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] match_dist2;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0] focal_x;
    logic [COORD_W-1:0] focal_y;
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
    logic [MCNT_W-1:0]  map_count;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic              load_wr;
    logic              start;
    logic              issue;
    logic [ADDR_W-1:0] addr;
    logic              finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_valid;
  } stat_t;

endpackage

// ===== rtl/projected_nearest_neighbour_search.sv =====
// ----------------------------------------------------------------------------
// projected_nearest_neighbour_search
// Loads a star map and, per detection, returns the nearest projected star.
// ----------------------------------------------------------------------------
// Load request: no result, one load per cycle while no query is in progress.
// Query request: N = min(map_count, 1024) entries are read one per cycle from
// the single store read port; once the pipeline drains the result register is
// loaded (an empty map skips the scan and drain) and the next request is taken
// after that, once a previous result no longer waits for out_ready.
// Reset: configuration registers return to reset values, control clears, the store is kept.
module projected_nearest_neighbour_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pnns_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pnns_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [pnns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pnns_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pnns_pkg::cfg_t  cfg;
  pnns_pkg::cmd_t  cmd;
  pnns_pkg::stat_t stat;

  pnns_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pnns_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_data.operation),
    .map_count    (cfg.map_count),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  pnns_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_data  (out_data)
  );

  assign out_valid = stat.out_valid;

`ifndef SYNTHESIS
  // an empty search reports a zero index and distance
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.match_found) |->
      (out_data.match_dist2 == '0 && out_data.match_index == '0))
    else $error("empty search result not zero");

  // a reported match lies inside the searched map
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.match_found) |->
      ({1'b0, out_data.match_index} < cfg.map_count))
    else $error("match index beyond searched map");

  // a query request leaves the controller busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.operation == pnns_pkg::OP_QUERY) |=> !in_ready)
    else $error("query request did not occupy the controller");
`endif

endmodule

// ===== rtl/pnns_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pnns_cfg_regs
// Configuration register file: camera intrinsics and searched map size.
// ----------------------------------------------------------------------------
module pnns_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pnns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pnns_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pnns_pkg::cfg_t                      cfg
);

  pnns_pkg::cfg_t cfg_r;
  pnns_pkg::cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pnns_pkg::REG_FOCAL_X:   cfg_nxt.focal_x   = cfg_data;
        pnns_pkg::REG_FOCAL_Y:   cfg_nxt.focal_y   = cfg_data;
        pnns_pkg::REG_CENTRE_X:  cfg_nxt.centre_x  = cfg_data;
        pnns_pkg::REG_CENTRE_Y:  cfg_nxt.centre_y  = cfg_data;
        pnns_pkg::REG_MAP_COUNT: cfg_nxt.map_count = cfg_data[pnns_pkg::MCNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x   <= pnns_pkg::FOCAL_X_RST;
      cfg_r.focal_y   <= pnns_pkg::FOCAL_Y_RST;
      cfg_r.centre_x  <= pnns_pkg::CENTRE_X_RST;
      cfg_r.centre_y  <= pnns_pkg::CENTRE_Y_RST;
      cfg_r.map_count <= pnns_pkg::MAP_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pnns_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnns_ctrl
// Sequencer: takes requests, walks the map addresses for a query, waits for
// the pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module pnns_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [pnns_pkg::MCNT_W-1:0]     map_count,
  input  logic                            out_ready,
  input  pnns_pkg::stat_t                 stat,
  output pnns_pkg::cmd_t                  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pnns_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pnns_pkg::CNT_W-1:0]   num_r, num_nxt;
  logic [pnns_pkg::CNT_W-1:0]   num_clip;
  logic                         in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // saturate the searched count at the store depth
  always_comb begin
    if (map_count > pnns_pkg::MCNT_W'(pnns_pkg::MAP_DEPTH)) begin
      num_clip = pnns_pkg::CNT_W'(pnns_pkg::MAP_DEPTH);
    end else begin
      num_clip = pnns_pkg::CNT_W'(map_count);
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    num_nxt     = num_r;
    cmd.load_wr = 1'b0;
    cmd.start   = 1'b0;
    cmd.issue   = 1'b0;
    cmd.addr    = cnt_r[pnns_pkg::ADDR_W-1:0];
    cmd.finish  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_operation == pnns_pkg::OP_QUERY) begin
            cmd.start = 1'b1;
            num_nxt   = num_clip;
            cnt_nxt   = '0;
            state_nxt = (num_clip == '0) ? S_DONE : S_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (cnt_r == num_r - pnns_pkg::CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + pnns_pkg::CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      num_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      num_r   <= num_nxt;
    end
  end

endmodule

// ===== rtl/pnns_dp.sv =====
// ----------------------------------------------------------------------------
// pnns_dp
// Datapath: map store, projection and distance pipeline, running minimum
// and the output register.
// ----------------------------------------------------------------------------
module pnns_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pnns_pkg::in_t        in_data,
  input  pnns_pkg::cfg_t       cfg,
  input  pnns_pkg::cmd_t       cmd,
  input  logic                 out_ready,
  output pnns_pkg::stat_t      stat,
  output pnns_pkg::out_t       out_data
);

  localparam int CW = pnns_pkg::COORD_W;
  localparam int AW = pnns_pkg::ADDR_W;

  // map store
  logic [CW-1:0] mem_x [pnns_pkg::MAP_DEPTH];
  logic [CW-1:0] mem_y [pnns_pkg::MAP_DEPTH];

  // pipeline valids
  logic v0_r, v1_r, v2_r, v3_r;

  // pipeline payload
  logic [AW-1:0]                      idx0_r, idx1_r, idx2_r, idx3_r;
  logic signed [CW-1:0]               rd_x_r, rd_y_r;
  logic signed [pnns_pkg::PROD_W-1:0] prod_x_r, prod_y_r;
  logic signed [pnns_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic [pnns_pkg::DIST_W-1:0]        sqx_r, sqy_r;
  logic [CW-1:0]                      det_x_r, det_y_r;

  // projection logic
  logic signed [pnns_pkg::PROD_W-1:0] rnd_x, rnd_y;
  logic signed [pnns_pkg::QUOT_W-1:0] q_x, q_y;
  logic signed [pnns_pkg::PROJ_W-1:0] mp_x, mp_y;
  logic signed [pnns_pkg::DIFF_W-1:0] dx_nxt, dy_nxt;
  logic [pnns_pkg::SQ_W-1:0]          sqx_full, sqy_full;
  logic [pnns_pkg::DIST_W-1:0]        d2;

  // running best and output register
  logic                        found_r;
  logic [pnns_pkg::DIST_W-1:0] best_d2_r;
  logic [AW-1:0]               best_i_r;
  logic                        out_valid_r;
  pnns_pkg::out_t              out_r;

  // write loads, read the scan address
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem_x[in_data.entry_index[AW-1:0]] <= in_data.star_x;
      mem_y[in_data.entry_index[AW-1:0]] <= in_data.star_y;
    end
    if (cmd.issue) begin
      rd_x_r <= mem_x[cmd.addr];
      rd_y_r <= mem_y[cmd.addr];
    end
  end

  // round to 1/16 px, add the principal point, take the difference
  always_comb begin
    rnd_x  = prod_x_r + pnns_pkg::PROD_W'(2048);
    rnd_y  = prod_y_r + pnns_pkg::PROD_W'(2048);
    q_x    = rnd_x[pnns_pkg::PROD_W-1:pnns_pkg::SHIFT];
    q_y    = rnd_y[pnns_pkg::PROD_W-1:pnns_pkg::SHIFT];
    mp_x   = {q_x[pnns_pkg::QUOT_W-1], q_x}
             + $signed({{(pnns_pkg::PROJ_W-CW){1'b0}}, cfg.centre_x});
    mp_y   = {q_y[pnns_pkg::QUOT_W-1], q_y}
             + $signed({{(pnns_pkg::PROJ_W-CW){1'b0}}, cfg.centre_y});
    dx_nxt = $signed({{(pnns_pkg::DIFF_W-CW){1'b0}}, det_x_r})
             - {mp_x[pnns_pkg::PROJ_W-1], mp_x};
    dy_nxt = $signed({{(pnns_pkg::DIFF_W-CW){1'b0}}, det_y_r})
             - {mp_y[pnns_pkg::PROJ_W-1], mp_y};
  end

  // square at full width
  assign sqx_full = $unsigned(pnns_pkg::SQ_W'(dx_r) * pnns_pkg::SQ_W'(dx_r));
  assign sqy_full = $unsigned(pnns_pkg::SQ_W'(dy_r) * pnns_pkg::SQ_W'(dy_r));
  assign d2       = sqx_r + sqy_r;

  // advance the pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      det_x_r <= in_data.det_x;
      det_y_r <= in_data.det_y;
    end
    idx0_r   <= cmd.addr;
    idx1_r   <= idx0_r;
    idx2_r   <= idx1_r;
    idx3_r   <= idx2_r;
    prod_x_r <= rd_x_r * $signed({1'b0, cfg.focal_x});
    prod_y_r <= rd_y_r * $signed({1'b0, cfg.focal_y});
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    sqx_r    <= sqx_full[pnns_pkg::DIST_W-1:0];
    sqy_r    <= sqy_full[pnns_pkg::DIST_W-1:0];
  end

  // track the closest star, first one wins on ties
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_d2_r <= '0;
      best_i_r  <= '0;
    end else if (v3_r && (!found_r || d2 < best_d2_r)) begin
      best_d2_r <= d2;
      best_i_r  <= idx3_r;
    end
  end

  // control: valids, found flag, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.start) begin
        found_r <= 1'b0;
      end else if (v3_r) begin
        found_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.match_found <= found_r;
      out_r.match_index <= pnns_pkg::IDX_W'(best_i_r);
      out_r.match_dist2 <= best_d2_r;
    end
  end

  assign stat.pipe_busy = v0_r || v1_r || v2_r || v3_r;
  assign stat.out_valid = out_valid_r;
  assign out_data       = out_r;

endmodule

// ===== tb/pnns_match_checker.sv =====
// ----------------------------------------------------------------------------
// pnns_match_checker
// Watches the request, result and register ports of the nearest neighbour
// search block. It keeps its own copy of the star map and the registers,
// predicts the nearest projected star for every query, and compares each
// result with the oldest prediction still owed.
// ----------------------------------------------------------------------------
module pnns_match_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  pnns_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  pnns_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [pnns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pnns_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              matches_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  logic [pnns_pkg::COORD_W-1:0] map_x [pnns_pkg::MAP_DEPTH];
  logic [pnns_pkg::COORD_W-1:0] map_y [pnns_pkg::MAP_DEPTH];
  pnns_pkg::cfg_t               regs;
  pnns_pkg::out_t               owed_matches [$];
  pnns_pkg::out_t               oldest;

  // Map one star coordinate to pixels in 1/16 px: round the product to
  // Q.4 (half up, floor division), then add the principal point.
  function automatic longint project_axis(input logic [pnns_pkg::COORD_W-1:0] star,
                                          input logic [pnns_pkg::COORD_W-1:0] focal,
                                          input logic [pnns_pkg::COORD_W-1:0] centre);
    longint prod;
    prod = longint'($signed(star)) * longint'(focal);
    return ((prod + 2048) >>> pnns_pkg::SHIFT) + longint'(centre);
  endfunction

  // Scan the searched slots in order; keep the first star at the minimum.
  function automatic pnns_pkg::out_t nearest_star(
      input logic [pnns_pkg::COORD_W-1:0] det_x,
      input logic [pnns_pkg::COORD_W-1:0] det_y);
    pnns_pkg::out_t best;
    int             n;
    int             i;
    longint         dx;
    longint         dy;
    longint         d2;
    best = '0;
    n = (regs.map_count > pnns_pkg::MAP_DEPTH) ? pnns_pkg::MAP_DEPTH
                                               : int'(regs.map_count);
    for (i = 0; i < n; i++) begin
      dx = longint'(det_x) - project_axis(map_x[i], regs.focal_x, regs.centre_x);
      dy = longint'(det_y) - project_axis(map_y[i], regs.focal_y, regs.centre_y);
      d2 = dx * dx + dy * dy;
      if (!best.match_found || d2 < longint'(best.match_dist2)) begin
        best.match_found = 1'b1;
        best.match_index = pnns_pkg::IDX_W'(i);
        best.match_dist2 = pnns_pkg::DIST_W'(d2);
      end
    end
    return best;
  endfunction

  // Count a failure; print only the first few.
  task automatic flag(input string what, input pnns_pkg::out_t want,
                      input pnns_pkg::out_t got);
    if (mismatches < REPORT_MAX) begin
      $display("%0t %s: expected found=%0d index=%0d dist2=%0d", $time, what,
               want.match_found, want.match_index, want.match_dist2);
      $display("%0t %s: actual   found=%0d index=%0d dist2=%0d", $time, what,
               got.match_found, got.match_index, got.match_dist2);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{pnns_pkg::FOCAL_X_RST, pnns_pkg::FOCAL_Y_RST, pnns_pkg::CENTRE_X_RST,
               pnns_pkg::CENTRE_Y_RST, pnns_pkg::MAP_COUNT_RST};
      owed_matches.delete();
    end else begin
      // track register writes
      if (cfg_we) begin
        case (cfg_index)
          pnns_pkg::REG_FOCAL_X:   regs.focal_x   = cfg_data;
          pnns_pkg::REG_FOCAL_Y:   regs.focal_y   = cfg_data;
          pnns_pkg::REG_CENTRE_X:  regs.centre_x  = cfg_data;
          pnns_pkg::REG_CENTRE_Y:  regs.centre_y  = cfg_data;
          pnns_pkg::REG_MAP_COUNT: regs.map_count = cfg_data[pnns_pkg::MCNT_W-1:0];
          default: ;
        endcase
      end

      // retire the oldest prediction before adding a new one
      if (out_valid && out_ready) begin
        if (owed_matches.size() == 0) begin
          flag("result with no query pending", '0, out_data);
        end else begin
          oldest = owed_matches.pop_front();
          if (out_data.match_found !== oldest.match_found ||
              out_data.match_index !== oldest.match_index ||
              out_data.match_dist2 !== oldest.match_dist2) begin
            flag("wrong match", oldest, out_data);
          end
        end
      end

      // apply loads, predict queries
      if (in_valid && in_ready) begin
        if (in_data.operation == pnns_pkg::OP_LOAD) begin
          map_x[in_data.entry_index] = in_data.star_x;
          map_y[in_data.entry_index] = in_data.star_y;
        end else begin
          owed_matches = {owed_matches, nearest_star(in_data.det_x, in_data.det_y)};
        end
      end
    end
    matches_owed = owed_matches.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the projected nearest neighbour search block.
// Loads map stars, reprograms the camera registers between phases and sends
// queries with random idling on both sides; a checker beside the block
// predicts every nearest match and counts the failures.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 40;
  localparam int PRESSURE_PHASE = 5;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  pnns_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_ready;
  pnns_pkg::out_t                  out_data;
  logic                            cfg_we;
  logic [pnns_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pnns_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              mismatches;
  int                              matches_owed;

  bit                              idle_on = 1'b1;
  bit                              hold_req = 1'b0;
  bit                              loaded [pnns_pkg::MAP_DEPTH];
  int                              prefix_len = 0;
  logic [pnns_pkg::COORD_W-1:0]    centre_now_x = pnns_pkg::CENTRE_X_RST;
  logic [pnns_pkg::COORD_W-1:0]    centre_now_y = pnns_pkg::CENTRE_Y_RST;
  int                              quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  projected_nearest_neighbour_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pnns_match_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .matches_owed (matches_owed)
  );

  // Mostly short gaps, a few long ones; none while idling is off.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [pnns_pkg::COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return pnns_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [pnns_pkg::COORD_W-1:0] pick_star();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return pnns_pkg::COORD_W'($urandom_range(0, 31) - 16);
    return pnns_pkg::COORD_W'($urandom);
  endfunction

  // Detections: edges, near the principal point, or anywhere.
  function automatic logic [pnns_pkg::COORD_W-1:0] pick_det(
      input logic [pnns_pkg::COORD_W-1:0] centre);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return centre + pnns_pkg::COORD_W'($urandom_range(0, 255) - 128);
    return pnns_pkg::COORD_W'($urandom);
  endfunction

  // Searched count never reaches past the contiguous loaded slots.
  function automatic int pick_count();
    int cap;
    cap = (prefix_len < 64) ? prefix_len : 64;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, cap);
    return $urandom_range(0, prefix_len);
  endfunction

  // Offer one request and return at the edge that takes it.
  task automatic send(input pnns_pkg::in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic load(input int slot, input logic [pnns_pkg::COORD_W-1:0] sx,
                      input logic [pnns_pkg::COORD_W-1:0] sy);
    pnns_pkg::in_t item;
    item.operation   = pnns_pkg::OP_LOAD;
    item.entry_index = pnns_pkg::IDX_W'(slot);
    item.star_x      = sx;
    item.star_y      = sy;
    item.det_x       = pnns_pkg::COORD_W'($urandom);
    item.det_y       = pnns_pkg::COORD_W'($urandom);
    loaded[slot] = 1'b1;
    while (prefix_len < pnns_pkg::MAP_DEPTH && loaded[prefix_len]) prefix_len++;
    send(item);
  endtask

  task automatic query(input logic [pnns_pkg::COORD_W-1:0] dx,
                       input logic [pnns_pkg::COORD_W-1:0] dy);
    pnns_pkg::in_t item;
    item.operation   = pnns_pkg::OP_QUERY;
    item.entry_index = pnns_pkg::IDX_W'($urandom);
    item.star_x      = pnns_pkg::COORD_W'($urandom);
    item.star_y      = pnns_pkg::COORD_W'($urandom);
    item.det_x       = dx;
    item.det_y       = dy;
    send(item);
  endtask

  task automatic put_reg(input logic [pnns_pkg::CFG_IDX_W-1:0] idx,
                         input logic [pnns_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Drain all owed results, let a trailing load finish, then rewrite registers.
  task automatic configure(input logic [pnns_pkg::COORD_W-1:0] fx,
                           input logic [pnns_pkg::COORD_W-1:0] fy,
                           input logic [pnns_pkg::COORD_W-1:0] cx,
                           input logic [pnns_pkg::COORD_W-1:0] cy,
                           input int count);
    in_valid <= 1'b0;
    do @(negedge clk); while (matches_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(pnns_pkg::REG_FOCAL_X, fx);
    put_reg(pnns_pkg::REG_FOCAL_Y, fy);
    put_reg(pnns_pkg::REG_CENTRE_X, cx);
    put_reg(pnns_pkg::REG_CENTRE_Y, cy);
    put_reg(pnns_pkg::REG_MAP_COUNT, pnns_pkg::CFG_DATA_W'(count));
    cfg_we <= 1'b0;
    centre_now_x = cx;
    centre_now_y = cy;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Abort when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    int k;
    int slot;
    int r;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= pnns_pkg::REG_FOCAL_X;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty map after reset: no match
    query(16'd10240, 16'd7680);

    // corner stars, a tied pair, and the top slot
    load(0, 16'h7FFF, 16'h8000);
    load(1, 16'h8000, 16'h7FFF);
    load(2, 16'h0000, 16'h0000);
    load(3, 16'h0000, 16'h0000);
    load(4, 16'hFFFF, 16'hFFFF);
    load(pnns_pkg::MAP_DEPTH - 1, pick_star(), pick_star());

    // default optics: slots 2 and 3 tie at zero distance, first one wins
    configure(16'd16384, 16'd16384, 16'd10240, 16'd7680, 5);
    query(16'd10240, 16'd7680);
    query(16'h0000, 16'h0000);
    query(16'hFFFF, 16'hFFFF);

    // largest focal lengths, principal point at the origin
    configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 5);
    query(16'h0000, 16'h0000);
    query(16'hFFFF, 16'hFFFF);
    query(16'h8000, 16'h8000);

    // zero focal length: every star lands on the centre, slot 0 wins
    configure(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 5);
    query(16'h0000, 16'h0000);

    // single searched slot, then an empty search again
    configure(16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 1);
    query(pnns_pkg::COORD_W'($urandom), pnns_pkg::COORD_W'($urandom));
    configure(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 0);
    query(pnns_pkg::COORD_W'($urandom), pnns_pkg::COORD_W'($urandom));

    // random phases: grow the map while querying it
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase % 4 != 1);
      if (phase == PRESSURE_PHASE) begin
        configure(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  (prefix_len < 8) ? prefix_len : 8);
        // stall results while requests keep coming
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end else begin
        configure(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_count());
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40 && phase != PRESSURE_PHASE) begin
          r = $urandom_range(0, 9);
          if (r < 5 && prefix_len < pnns_pkg::MAP_DEPTH) begin
            slot = prefix_len;
          end else if (r < 7 && prefix_len > 0) begin
            slot = $urandom_range(0, prefix_len - 1);
          end else begin
            slot = $urandom_range(0, pnns_pkg::MAP_DEPTH - 1);
          end
          load(slot, pick_star(), pick_star());
        end else begin
          query(pick_det(centre_now_x), pick_det(centre_now_y));
        end
      end
    end

    // search the whole contiguous loaded prefix
    idle_on = 1'b1;
    configure(pick_coord(), pick_coord(), pick_coord(), pick_coord(), prefix_len);
    query(pick_det(centre_now_x), pick_det(centre_now_y));
    query(pnns_pkg::COORD_W'($urandom), pnns_pkg::COORD_W'($urandom));

    // drain and decide
    in_valid <= 1'b0;
    do @(negedge clk); while (matches_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && matches_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
